FILE: rtl/core/lfu_pkg.sv
// ---------------------------------------------------------------------------
// LFU page replacement package
// Shared sizes, microcode types and the control and status structures that
// pass between the sequencer and the datapath.
// ---------------------------------------------------------------------------
package lfu_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGES     = 64;
    localparam int PAGE_W    = 6;
    localparam int FRAME_W   = 3;
    localparam int FCNT_W    = 4;
    localparam int COUNT_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int TALLY_W   = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;

    localparam logic [FCNT_W-1:0]  FCNT_RESET = FCNT_W'(FRAMES);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPD,
        ST_SCAN,
        ST_SCHK,
        ST_VISS,
        ST_VCMP,
        ST_EVICT,
        ST_OUT
    } step_t;

    typedef enum logic [3:0] {
        ACT_ACCEPT,
        ACT_READ,
        ACT_UPDATE,
        ACT_SCAN,
        ACT_NOP,
        ACT_VISSUE,
        ACT_VCMP,
        ACT_EVICT,
        ACT_OUTPUT
    } action_t;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_IN_VALID,
        CND_SCAN_STOP,
        CND_FOUND,
        CND_VLAST,
        CND_OUT_FREE
    } cond_t;

    typedef struct packed {
        action_t action;
        cond_t   cond;
        step_t   target;
        logic    advance;
    } uword_t;

    typedef struct packed {
        action_t action;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic scan_stop;
        logic found;
        logic vlast;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/lfu_sequencer.sv
// ---------------------------------------------------------------------------
// LFU sequencer
// Step counter and read-only microcode table; each control word names the
// datapath action, a branch condition and a branch target.
// ---------------------------------------------------------------------------
module lfu_sequencer
    import lfu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   taken;

    function automatic uword_t rom(input step_t s);
        uword_t w;
        case (s)
            ST_IDLE:  w = '{ACT_ACCEPT, CND_IN_VALID,  ST_READ,  1'b0};
            ST_READ:  w = '{ACT_READ,   CND_ALWAYS,    ST_UPD,   1'b0};
            ST_UPD:   w = '{ACT_UPDATE, CND_ALWAYS,    ST_SCAN,  1'b0};
            ST_SCAN:  w = '{ACT_SCAN,   CND_SCAN_STOP, ST_SCHK,  1'b0};
            ST_SCHK:  w = '{ACT_NOP,    CND_FOUND,     ST_OUT,   1'b1};
            ST_VISS:  w = '{ACT_VISSUE, CND_ALWAYS,    ST_VCMP,  1'b0};
            ST_VCMP:  w = '{ACT_VCMP,   CND_VLAST,     ST_EVICT, 1'b0};
            ST_EVICT: w = '{ACT_EVICT,  CND_ALWAYS,    ST_OUT,   1'b0};
            ST_OUT:   w = '{ACT_OUTPUT, CND_OUT_FREE,  ST_IDLE,  1'b0};
            default:  w = '{ACT_NOP,    CND_ALWAYS,    ST_IDLE,  1'b0};
        endcase
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        uw = rom(step_reg);
        case (uw.cond)
            CND_ALWAYS:    taken = 1'b1;
            CND_IN_VALID:  taken = status.in_valid;
            CND_SCAN_STOP: taken = status.scan_stop;
            CND_FOUND:     taken = status.found;
            CND_VLAST:     taken = status.vlast;
            CND_OUT_FREE:  taken = status.out_free;
            default:       taken = 1'b1;
        endcase
        if (taken) begin
            step_next = uw.target;
        end else if (uw.advance) begin
            step_next = step_t'(step_reg + 4'd1);
        end else begin
            step_next = step_reg;
        end
        ctrl.action = uw.action;
    end

endmodule

FILE: rtl/core/lfu_datapath.sv
// ---------------------------------------------------------------------------
// LFU datapath
// Frame table, use-count and last-use memories, tallies, victim search
// registers and the result register, all driven by the sequencer's actions.
// ---------------------------------------------------------------------------
module lfu_datapath
    import lfu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_t                ctrl,
    output status_t              status,
    input  logic                 cfg_we,
    input  logic [FCNT_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [FCNT_W-1:0]  fcnt_reg;
    logic [FRAME_W-1:0] n_last;

    logic [PAGE_W-1:0]  frame_page_reg [FRAMES];
    logic [FRAMES-1:0]  frame_used_reg;

    logic [COUNT_W-1:0] cnt_mem   [PAGES];
    logic [STAMP_W-1:0] stamp_mem [PAGES];
    logic [PAGES-1:0]   cnt_vld_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;
    logic               vld_rd_reg;
    logic [COUNT_W-1:0] cnt_cur;

    logic               rd_en;
    logic [PAGE_W-1:0]  rd_addr;

    logic [PAGE_W-1:0]  pg_reg;
    logic [STAMP_W-1:0] seq_reg;
    logic [TALLY_W-1:0] hit_tally_reg;
    logic [TALLY_W-1:0] fault_tally_reg;

    logic [FRAME_W-1:0] idx_reg;
    logic [FRAME_W-1:0] cmp_idx_reg;
    logic               found_reg;
    logic               hit_reg;
    logic [FRAME_W-1:0] slot_reg;
    logic               ev_valid_reg;
    logic [PAGE_W-1:0]  ev_page_reg;

    logic               have_reg;
    logic [COUNT_W-1:0] best_cnt_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [FRAME_W-1:0] victim_reg;
    logic               better;

    logic               fill;
    logic               match;
    logic               out_free;
    logic               accept;
    logic               m_load;

    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    always_comb begin
        if (fcnt_reg == '0) begin
            n_last = '0;
        end else if (fcnt_reg > FCNT_W'(FRAMES)) begin
            n_last = FRAME_W'(FRAMES - 1);
        end else begin
            n_last = FRAME_W'(fcnt_reg - 4'd1);
        end
    end

    assign s_tready = (ctrl.action == ACT_ACCEPT);
    assign accept   = s_tready && s_tvalid;
    assign out_free = !m_valid_reg || m_tready;
    assign m_load   = (ctrl.action == ACT_OUTPUT) && out_free;
    assign fill     = !frame_used_reg[idx_reg];
    assign match    = frame_page_reg[idx_reg] == pg_reg;
    assign cnt_cur  = vld_rd_reg ? cnt_rd_reg : '0;

    assign better = !have_reg || (cnt_cur < best_cnt_reg) ||
                    ((cnt_cur == best_cnt_reg) && (stamp_rd_reg < best_stamp_reg));

    always_comb begin
        status.in_valid  = s_tvalid;
        status.scan_stop = fill || match || (idx_reg == n_last);
        status.found     = found_reg;
        status.vlast     = cmp_idx_reg == n_last;
        status.out_free  = out_free;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = pg_reg;
        case (ctrl.action)
            ACT_READ: begin
                rd_en = 1'b1;
            end
            ACT_VISSUE: begin
                rd_en   = 1'b1;
                rd_addr = frame_page_reg[0];
            end
            ACT_VCMP: begin
                rd_en   = 1'b1;
                rd_addr = frame_page_reg[idx_reg];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cnt_rd_reg   <= cnt_mem[rd_addr];
            stamp_rd_reg <= stamp_mem[rd_addr];
            vld_rd_reg   <= cnt_vld_reg[rd_addr];
        end
        if (ctrl.action == ACT_UPDATE) begin
            cnt_mem[pg_reg]   <= (cnt_cur == COUNT_MAX) ? COUNT_MAX : cnt_cur + 16'd1;
            stamp_mem[pg_reg] <= seq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcnt_reg        <= FCNT_RESET;
            frame_used_reg  <= '0;
            cnt_vld_reg     <= '0;
            seq_reg         <= '0;
            hit_tally_reg   <= '0;
            fault_tally_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                fcnt_reg <= cfg_wdata;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.action)
                ACT_ACCEPT: begin
                    if (accept) begin
                        pg_reg <= s_tdata[PAGE_W-1:0];
                    end
                end
                ACT_UPDATE: begin
                    cnt_vld_reg[pg_reg] <= 1'b1;
                    seq_reg             <= seq_reg + 32'd1;
                    idx_reg             <= '0;
                    found_reg           <= 1'b0;
                    hit_reg             <= 1'b0;
                    ev_valid_reg        <= 1'b0;
                    ev_page_reg         <= '0;
                end
                ACT_SCAN: begin
                    if (fill) begin
                        frame_used_reg[idx_reg] <= 1'b1;
                        frame_page_reg[idx_reg] <= pg_reg;
                        fault_tally_reg         <= fault_tally_reg + 32'd1;
                        slot_reg                <= idx_reg;
                        found_reg               <= 1'b1;
                    end else if (match) begin
                        hit_reg       <= 1'b1;
                        hit_tally_reg <= hit_tally_reg + 32'd1;
                        slot_reg      <= idx_reg;
                        found_reg     <= 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                ACT_VISSUE: begin
                    have_reg    <= 1'b0;
                    cmp_idx_reg <= '0;
                    idx_reg     <= 3'd1;
                end
                ACT_VCMP: begin
                    if (better) begin
                        have_reg       <= 1'b1;
                        best_cnt_reg   <= cnt_cur;
                        best_stamp_reg <= stamp_rd_reg;
                        victim_reg     <= cmp_idx_reg;
                    end
                    cmp_idx_reg <= idx_reg;
                    idx_reg     <= idx_reg + 3'd1;
                end
                ACT_EVICT: begin
                    cnt_vld_reg[frame_page_reg[victim_reg]] <= 1'b0;
                    frame_page_reg[victim_reg] <= pg_reg;
                    ev_valid_reg    <= 1'b1;
                    ev_page_reg     <= frame_page_reg[victim_reg];
                    slot_reg        <= victim_reg;
                    fault_tally_reg <= fault_tally_reg + 32'd1;
                end
                ACT_OUTPUT: begin
                    if (out_free) begin
                        m_data_reg  <= {5'd0, fault_tally_reg, hit_tally_reg,
                                        ev_page_reg, ev_valid_reg, slot_reg, hit_reg};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/core/lfu_page_replacement.sv
// ---------------------------------------------------------------------------
// LFU page replacement
// Least-frequently-used page replacement with oldest-use tie-break.
// ---------------------------------------------------------------------------
// Each transaction on the s_ channel carries one page reference; each one
// produces exactly one transaction on the m_ channel that reports hit or
// fault, the frame now holding the page, any evicted page and the running
// hit and fault totals.
// A reference on a hit or a fill into an empty frame steps through accept,
// memory read, count update, frame scan, check and output. When every active
// frame is full, a victim search over the active frames and an eviction come
// before the output. The frame scan walks one frame per cycle and the victim
// search reads one use count and one last-use stamp per cycle through the
// single memory read port.
// One reference is in flight at a time; s_tready is high only while the
// sequencer waits for a new reference.
// The result is held in an output register. If the receiver stalls, the
// block still accepts and processes the next reference, then waits with
// that result until the register is free.
// Reset empties all frames, clears all use counts, sequence and totals,
// and sets frame_count to 8. Write frame_count only while idle; not enforced.
// ---------------------------------------------------------------------------
module lfu_page_replacement
    import lfu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [FCNT_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: page [5:0], zero [7:6]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: hit [0], frame_index [3:1], evicted_valid [4],
    // evicted_page [10:5], hits_total [42:11], faults_total [74:43], zero [79:75]
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctrl_t   ctrl;
    status_t status;

    lfu_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    lfu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: rtl/core/lfu_checker.sv
// ---------------------------------------------------------------------------
// LFU port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ---------------------------------------------------------------------------
module lfu_checker
    import lfu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid directly after reset.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed or dropped.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second reference accepted while one is in flight.");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[4])
        else $error("Hit reported together with an eviction.");

    a_no_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[4] |-> m_tdata[10:5] == '0)
        else $error("Evicted page not zero without an eviction.");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
